>>> hdl/c2d_pkg.sv
// Shared types, codes and helpers for the 2D convolution block.
package c2d_pkg;

  // Default store dimensions
  localparam int MAX_WIDTH_DEF       = 32;
  localparam int MAX_HEIGHT_DEF      = 32;
  localparam int MAX_PLANES_DEF      = 8;
  localparam int MAX_KERNEL_SIDE_DEF = 7;
  localparam int MAX_KERNELS_DEF     = 8;

  // Word width of every store entry (Q8.8 samples and biases, Q4.12 weights)
  localparam int DATA_W = 16;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_LOAD_SAMPLE = 2'd2,
    OP_COMPUTE     = 2'd3
  } c2d_op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_IN_WIDTH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_IN_DEPTH    = 3'd2,
    REG_KERN_WIDTH  = 3'd3,
    REG_KERN_HEIGHT = 3'd4,
    REG_KERN_COUNT  = 3'd5,
    REG_STRIDE      = 3'd6,
    REG_PAD         = 3'd7
  } c2d_reg_t;

  // Input request payload
  typedef struct packed {
    c2d_op_t            op;
    logic [2:0]         channel;
    logic [2:0]         plane;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } c2d_in_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] result;
    logic               bad_position;
  } c2d_out_t;

  // Current layer geometry
  typedef struct packed {
    logic [5:0] in_width;
    logic [5:0] in_height;
    logic [3:0] in_depth;
    logic [2:0] kern_width;
    logic [2:0] kern_height;
    logic [3:0] kern_count;
    logic [2:0] stride;
    logic [1:0] pad;
  } c2d_cfg_t;

  // Tag that travels with each memory read down the MAC pipeline
  typedef struct packed {
    logic vld;    // read slot carries work
    logic first;  // clear accumulator
    logic last;   // final term of the sum
    logic bias;   // coefficient word is a bias to align and add
    logic mask;   // tap inside the plane: add sample times weight
    logic bad;    // request outside the output volume
  } c2d_tap_t;

  // Clamp a register value into 1..hi
  function automatic logic [7:0] c2d_clamp(input logic [7:0] v, input int hi);
    logic [7:0] r;
    if (v == 8'd0) begin
      r = 8'd1;
    end else if (int'(v) > hi) begin
      r = 8'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hdl/conv2d_stride_pad_bias.sv
// Top level of the 2D convolution block: register port, load decode, stores and datapath.
//
// Multi-channel 2D convolution with stride, zero padding and a bias per output position.
// Loads (weight, bias, sample) are taken one per cycle while no compute is running and are
// written straight into the stores; they give no result. A compute request returns one
// Q16.16 value, floor-shifted and saturated, or a zero with bad_position set when the
// position is outside the output volume. A compute request stalls the input from
// acceptance until its result is written into the result register; a previous result
// still held by out_stall delays the finish for as long as it stays held. One bias read,
// then one tap per cycle go through the single read port of the sample and coefficient
// memories into one multiply-accumulate, followed by the read, product, accumulate and
// result registers. A bad request skips the bias read and taps and sends one empty term
// through the same registers. Padded taps are still stepped through and add zero.
// Weights and biases share the coefficient memory. Stores are not cleared; no entry may
// be read before it is written. Configuration writes take effect at once; write the
// registers only while no request is in flight.
module conv2d_stride_pad_bias
  import c2d_pkg::*;
#(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
  parameter int MAX_PLANES      = MAX_PLANES_DEF,
  parameter int MAX_KERNEL_SIDE = MAX_KERNEL_SIDE_DEF,
  parameter int MAX_KERNELS     = MAX_KERNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  c2d_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output c2d_out_t    out_data
);

  localparam int KSLOT      = MAX_KERNEL_SIDE + 1;
  localparam int PLANE_AREA = MAX_WIDTH * MAX_HEIGHT;
  localparam int SAMP_DEPTH = MAX_PLANES * PLANE_AREA;
  localparam int WGT_DEPTH  = MAX_KERNELS * MAX_PLANES * KSLOT * KSLOT;
  localparam int BIAS_DEPTH = MAX_KERNELS * PLANE_AREA;
  localparam int COEF_DEPTH = WGT_DEPTH + BIAS_DEPTH;
  localparam int SA_W       = (SAMP_DEPTH > 1) ? $clog2(SAMP_DEPTH) : 1;
  localparam int CA_W       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

  logic [5:0] in_width_r, in_height_r;
  logic [3:0] in_depth_r, kern_count_r;
  logic [2:0] kern_width_r, kern_height_r, stride_r;
  logic [1:0] pad_r;
  c2d_cfg_t   cfg;
  c2d_reg_t   reg_idx;
  logic       cfg_we;

  logic                     in_acc;
  logic                     wgt_ok, bias_ok, samp_ok;
  logic                     samp_we, coef_we;
  logic [SA_W-1:0]          samp_waddr, samp_raddr;
  logic [CA_W-1:0]          coef_waddr, coef_raddr;
  logic signed [DATA_W-1:0] samp_rdata, coef_rdata;
  logic                     start, busy, done;
  c2d_tap_t                 tag;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = c2d_reg_t'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r    <= 6'(c2d_clamp(8'd32, MAX_WIDTH));
      in_height_r   <= 6'(c2d_clamp(8'd32, MAX_HEIGHT));
      in_depth_r    <= 4'(c2d_clamp(8'd1, MAX_PLANES));
      kern_width_r  <= 3'(c2d_clamp(8'd3, MAX_KERNEL_SIDE));
      kern_height_r <= 3'(c2d_clamp(8'd3, MAX_KERNEL_SIDE));
      kern_count_r  <= 4'(c2d_clamp(8'd1, MAX_KERNELS));
      stride_r      <= 3'd1;
      pad_r         <= 2'd0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_IN_WIDTH:    in_width_r    <= 6'(c2d_clamp({2'b0, pwdata[5:0]}, MAX_WIDTH));
        REG_IN_HEIGHT:   in_height_r   <= 6'(c2d_clamp({2'b0, pwdata[5:0]}, MAX_HEIGHT));
        REG_IN_DEPTH:    in_depth_r    <= 4'(c2d_clamp({4'b0, pwdata[3:0]}, MAX_PLANES));
        REG_KERN_WIDTH:  kern_width_r  <= 3'(c2d_clamp({5'b0, pwdata[2:0]},
                                                       MAX_KERNEL_SIDE));
        REG_KERN_HEIGHT: kern_height_r <= 3'(c2d_clamp({5'b0, pwdata[2:0]},
                                                       MAX_KERNEL_SIDE));
        REG_KERN_COUNT:  kern_count_r  <= 4'(c2d_clamp({4'b0, pwdata[3:0]}, MAX_KERNELS));
        REG_STRIDE:      stride_r      <= 3'(c2d_clamp({5'b0, pwdata[2:0]}, 4));
        REG_PAD:         pad_r         <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_IN_WIDTH:    prdata = {26'b0, in_width_r};
      REG_IN_HEIGHT:   prdata = {26'b0, in_height_r};
      REG_IN_DEPTH:    prdata = {28'b0, in_depth_r};
      REG_KERN_WIDTH:  prdata = {29'b0, kern_width_r};
      REG_KERN_HEIGHT: prdata = {29'b0, kern_height_r};
      REG_KERN_COUNT:  prdata = {28'b0, kern_count_r};
      REG_STRIDE:      prdata = {29'b0, stride_r};
      REG_PAD:         prdata = {30'b0, pad_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{in_width: in_width_r, in_height: in_height_r, in_depth: in_depth_r,
                 kern_width: kern_width_r, kern_height: kern_height_r,
                 kern_count: kern_count_r, stride: stride_r, pad: pad_r};

  // Load decode: out-of-range loads are dropped
  assign in_acc = in_valid && !in_stall;
  assign start  = in_acc && (in_data.op == OP_COMPUTE);

  always_comb begin
    wgt_ok  = (int'(in_data.channel) < MAX_KERNELS) && (int'(in_data.plane) < MAX_PLANES) &&
              (int'(in_data.row) < MAX_KERNEL_SIDE) && (int'(in_data.col) < MAX_KERNEL_SIDE);
    bias_ok = (int'(in_data.channel) < MAX_KERNELS) && (int'(in_data.row) < MAX_HEIGHT) &&
              (int'(in_data.col) < MAX_WIDTH);
    samp_ok = (int'(in_data.plane) < MAX_PLANES) && (int'(in_data.row) < MAX_HEIGHT) &&
              (int'(in_data.col) < MAX_WIDTH);
    samp_we = in_acc && (in_data.op == OP_LOAD_SAMPLE) && samp_ok;
    coef_we = in_acc && (((in_data.op == OP_LOAD_WEIGHT) && wgt_ok) ||
                         ((in_data.op == OP_LOAD_BIAS) && bias_ok));
    samp_waddr = SA_W'((int'(in_data.plane) * MAX_HEIGHT + int'(in_data.row)) * MAX_WIDTH +
                       int'(in_data.col));
    if (in_data.op == OP_LOAD_WEIGHT) begin
      coef_waddr = CA_W'(((int'(in_data.channel) * MAX_PLANES + int'(in_data.plane)) * KSLOT +
                          int'(in_data.row)) * KSLOT + int'(in_data.col));
    end else begin
      coef_waddr = CA_W'(WGT_DEPTH + (int'(in_data.channel) * MAX_HEIGHT +
                          int'(in_data.row)) * MAX_WIDTH + int'(in_data.col));
    end
  end

  assign in_stall = busy;

  // Sample store
  c2d_ram #(
    .DEPTH  (SAMP_DEPTH),
    .ADDR_W (SA_W),
    .WORD_W (DATA_W)
  ) u_samp_ram (
    .clk     (clk),
    .wr_en   (samp_we),
    .wr_addr (samp_waddr),
    .wr_data (in_data.value),
    .rd_addr (samp_raddr),
    .rd_data (samp_rdata)
  );

  // Coefficient store: weights, then biases
  c2d_ram #(
    .DEPTH  (COEF_DEPTH),
    .ADDR_W (CA_W),
    .WORD_W (DATA_W)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_we),
    .wr_addr (coef_waddr),
    .wr_data (in_data.value),
    .rd_addr (coef_raddr),
    .rd_data (coef_rdata)
  );

  c2d_seq #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_PLANES      (MAX_PLANES),
    .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
    .MAX_KERNELS     (MAX_KERNELS),
    .SA_W            (SA_W),
    .CA_W            (CA_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (start),
    .req        (in_data),
    .done       (done),
    .busy       (busy),
    .samp_raddr (samp_raddr),
    .coef_raddr (coef_raddr),
    .tag        (tag)
  );

  c2d_acc #(
    .MAX_PLANES      (MAX_PLANES),
    .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (tag),
    .samp_rdata (samp_rdata),
    .coef_rdata (coef_rdata),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .done       (done)
  );

endmodule

>>> hdl/c2d_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module c2d_ram
  import c2d_pkg::*;
#(
  parameter int DEPTH   = 1024,
  parameter int ADDR_W  = 10,
  parameter int WORD_W  = DATA_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/c2d_seq.sv
// Tap sequencer: checks the output position and issues bias and tap reads.
module c2d_seq
  import c2d_pkg::*;
#(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
  parameter int MAX_PLANES      = MAX_PLANES_DEF,
  parameter int MAX_KERNEL_SIDE = MAX_KERNEL_SIDE_DEF,
  parameter int MAX_KERNELS     = MAX_KERNELS_DEF,
  parameter int SA_W            = 13,
  parameter int CA_W            = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  c2d_cfg_t        cfg,
  input  logic            start,
  input  c2d_in_t         req,
  input  logic            done,
  output logic            busy,
  output logic [SA_W-1:0] samp_raddr,
  output logic [CA_W-1:0] coef_raddr,
  output c2d_tap_t        tag
);

  localparam int KSLOT     = MAX_KERNEL_SIDE + 1;
  localparam int WGT_DEPTH = MAX_KERNELS * MAX_PLANES * KSLOT * KSLOT;

  typedef enum logic [1:0] {S_IDLE, S_BIAS, S_TAP, S_WAIT} state_t;

  state_t             state_r;
  logic [2:0]         ch_r;
  logic [4:0]         row_r;
  logic [4:0]         col_r;
  logic signed [9:0]  y0_r;
  logic signed [9:0]  x0_r;
  logic [2:0]         kr_r;
  logic [2:0]         kc_r;
  logic [3:0]         d_r;
  c2d_tap_t           tag_r;

  logic [8:0]         row_span, col_span, h_span, w_span;
  logic               bad_req;
  logic signed [9:0]  y0_nxt, x0_nxt;
  logic signed [9:0]  y, x;
  logic               tap_in;
  logic               bias_ok;
  logic               d_end, kc_end, kr_end;
  logic [CA_W-1:0]    wgt_addr, bias_addr;

  // Position check: row is valid when row*stride + kern <= in + 2*pad
  always_comb begin
    row_span = 9'(req.row) * 9'(cfg.stride) + 9'(cfg.kern_height);
    col_span = 9'(req.col) * 9'(cfg.stride) + 9'(cfg.kern_width);
    h_span   = 9'(cfg.in_height) + 9'({cfg.pad, 1'b0});
    w_span   = 9'(cfg.in_width) + 9'({cfg.pad, 1'b0});
    bad_req  = ({1'b0, req.channel} >= cfg.kern_count) ||
               (row_span > h_span) || (col_span > w_span);
    y0_nxt   = $signed(10'(req.row) * 10'(cfg.stride)) - $signed(10'(cfg.pad));
    x0_nxt   = $signed(10'(req.col) * 10'(cfg.stride)) - $signed(10'(cfg.pad));
  end

  // Tap position and store addresses
  always_comb begin
    y       = y0_r + $signed(10'(kr_r));
    x       = x0_r + $signed(10'(kc_r));
    tap_in  = !y[9] && !x[9] &&
              (y[8:0] < 9'(cfg.in_height)) && (x[8:0] < 9'(cfg.in_width));
    bias_ok = (int'(row_r) < MAX_HEIGHT) && (int'(col_r) < MAX_WIDTH);
    samp_raddr = SA_W'((int'(d_r) * MAX_HEIGHT + int'(y[8:0])) * MAX_WIDTH +
                       int'(x[8:0]));
    wgt_addr   = CA_W'(((int'(ch_r) * MAX_PLANES + int'(d_r)) * KSLOT + int'(kr_r)) *
                       KSLOT + int'(kc_r));
    bias_addr  = CA_W'(WGT_DEPTH + (int'(ch_r) * MAX_HEIGHT + int'(row_r)) * MAX_WIDTH +
                       int'(col_r));
    coef_raddr = (state_r == S_BIAS) ? bias_addr : wgt_addr;
    d_end  = (d_r == cfg.in_depth - 4'd1);
    kc_end = (kc_r == cfg.kern_width - 3'd1);
    kr_end = (kr_r == cfg.kern_height - 3'd1);
  end

  // State, loop counters and read tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tag_r   <= '0;
      kr_r    <= '0;
      kc_r    <= '0;
      d_r     <= '0;
    end else begin
      tag_r <= '0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            ch_r  <= req.channel;
            row_r <= req.row;
            col_r <= req.col;
            y0_r  <= y0_nxt;
            x0_r  <= x0_nxt;
            kr_r  <= '0;
            kc_r  <= '0;
            d_r   <= '0;
            if (bad_req) begin
              // single empty term, flagged bad
              tag_r <= '{vld: 1'b1, first: 1'b1, last: 1'b1,
                         bias: 1'b0, mask: 1'b0, bad: 1'b1};
              state_r <= S_WAIT;
            end else begin
              state_r <= S_BIAS;
            end
          end
        end
        S_BIAS: begin
          tag_r <= '{vld: 1'b1, first: 1'b1, last: 1'b0,
                     bias: bias_ok, mask: 1'b0, bad: 1'b0};
          state_r <= S_TAP;
        end
        S_TAP: begin
          tag_r <= '{vld: 1'b1, first: 1'b0, last: d_end && kc_end && kr_end,
                     bias: 1'b0, mask: tap_in, bad: 1'b0};
          // plane innermost, then kernel column, then kernel row
          if (d_end) begin
            d_r <= '0;
            if (kc_end) begin
              kc_r <= '0;
              if (kr_end) begin
                state_r <= S_WAIT;
              end else begin
                kr_r <= kr_r + 3'd1;
              end
            end else begin
              kc_r <= kc_r + 3'd1;
            end
          end else begin
            d_r <= d_r + 4'd1;
          end
        end
        S_WAIT: begin
          if (done) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign tag  = tag_r;

endmodule

>>> hdl/c2d_acc.sv
// MAC pipeline: product register, accumulator, rounding, saturation, result register.
module c2d_acc
  import c2d_pkg::*;
#(
  parameter int MAX_PLANES      = MAX_PLANES_DEF,
  parameter int MAX_KERNEL_SIDE = MAX_KERNEL_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  c2d_tap_t                 tag,
  input  logic signed [DATA_W-1:0] samp_rdata,
  input  logic signed [DATA_W-1:0] coef_rdata,
  input  logic                     out_stall,
  output logic                     out_valid,
  output c2d_out_t                 out_data,
  output logic                     done
);

  // Headroom for every tap plus the bias, and at least 33 bits after the shift
  localparam int ACC_W = 36 + $clog2(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE * MAX_PLANES + 1);
  localparam int QW    = ACC_W - 4;

  logic signed [31:0]      prod_nxt;
  logic signed [31:0]      prod_r;
  c2d_tap_t                tb_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    fin_r;
  logic                    bad_r;
  logic                    out_valid_r;
  c2d_out_t                out_data_r;

  logic signed [QW-1:0]    q;
  logic [QW-32:0]          q_hi;
  logic signed [31:0]      sat;

  // Term select: sample times weight, aligned bias, or nothing
  always_comb begin
    if (tag.mask) begin
      prod_nxt = samp_rdata * coef_rdata;
    end else if (tag.bias) begin
      prod_nxt = {{4{coef_rdata[15]}}, coef_rdata, 12'b0};
    end else begin
      prod_nxt = '0;
    end
  end

  // Floor shift to Q16.16 and clip to 32 bits
  always_comb begin
    q    = QW'(acc_r >>> 4);
    q_hi = q[QW-1:31];
    if ((&q_hi) || !(|q_hi)) begin
      sat = q[31:0];
    end else if (q[QW-1]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

  assign done = fin_r && (!out_valid_r || !out_stall);

  // Product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r <= '0;
    end else begin
      tb_r <= tag;
    end
    prod_r <= prod_nxt;
  end

  // Accumulate stage and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tb_r.vld) begin
        acc_r <= (tb_r.first ? '0 : acc_r) + ACC_W'(prod_r);
        if (tb_r.last) begin
          fin_r <= 1'b1;
          bad_r <= tb_r.bad;
        end
      end
      if (done) begin
        fin_r       <= 1'b0;
        out_valid_r <= 1'b1;
        out_data_r  <= '{result: sat, bad_position: bad_r};
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/c2d_checker.sv
// Port-level assertions for the 2D convolution block, bound to the top level.
module c2d_checker
  import c2d_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input c2d_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input c2d_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A bad position always reports a zero value
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.bad_position || (out_data.result == 32'sd0))
    else $error("bad position with nonzero result");

  // An accepted compute request blocks further requests
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == OP_COMPUTE) |=> in_stall)
    else $error("request taken while computing");

  // A new result only comes out of a running compute
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a compute in progress");

endmodule

bind conv2d_stride_pad_bias c2d_checker u_c2d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
